// ===== src/tsn_pkg.sv =====
// Shared constants, types and command structs for the timestamped sample store.
`default_nettype none
package tsn_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TICK_W          = 32;
  localparam int SAMPLE_W        = 8;
  localparam int OP_W            = 2;
  localparam int ST_W            = 2;
  localparam int DATA_W          = TICK_W + SAMPLE_W;

  typedef logic [TICK_W-1:0]          tick_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [OP_W-1:0]            op_t;
  typedef logic [ST_W-1:0]            status_t;

  localparam op_t OP_INSERT  = 2'd0;
  localparam op_t OP_NEAREST = 2'd1;
  localparam op_t OP_PRUNE   = 2'd2;
  localparam op_t OP_NEWEST  = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FAR   = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef struct packed {
    logic start;
    logic read;
    logic calc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/tsn_ctrl.sv =====
// Controller state machine that sequences the table scan of one request.
`default_nettype none
module tsn_ctrl
  import tsn_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.read = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/tsn_dp.sv =====
// Datapath: entry memory, valid bits, scan trackers, result register and limit register.
`default_nettype none
module tsn_dp
  import tsn_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  wire  [OP_W-1:0]   in_op,
  input  wire  [TICK_W-1:0] in_tick,
  input  wire  [SAMPLE_W-1:0] in_sample,
  input  wire               cfg_wr_en,
  input  wire  [TICK_W-1:0] cfg_wr_data,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic [ST_W-1:0]   out_tuser
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  typedef logic [IDX_W-1:0] idx_t;

  tick_t   mem_tick [TABLE_DEPTH];
  sample_t mem_sample [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  tick_t   max_dist_r;
  op_t     req_op_r;
  tick_t   req_tick_r;
  sample_t req_sample_r;

  idx_t    idx_r;
  logic    rd_pend_r;
  idx_t    rd_idx_r;
  logic    rd_valid_r;
  tick_t   rd_tick_r;
  sample_t rd_sample_r;

  logic    match_r;
  idx_t    match_idx_r;
  sample_t match_sample_r;
  logic    free_r;
  idx_t    free_idx_r;
  logic    exact_r;
  sample_t exact_sample_r;
  logic    lo_r;
  tick_t   lo_tick_r;
  sample_t lo_sample_r;
  logic    hi_r;
  tick_t   hi_tick_r;
  sample_t hi_sample_r;
  tick_t   d_lo_r;
  tick_t   d_hi_r;

  logic    out_valid_r;
  status_t out_status_r;
  tick_t   out_tick_r;
  sample_t out_sample_r;

  logic    ev;
  logic    ev_eq;
  logic    ev_lt;
  logic    ins_wr;
  idx_t    ins_idx;
  sample_t ins_sample;
  logic    lo_wins;
  logic    lo_far;
  logic    hi_far;
  status_t res_status;
  tick_t   res_tick;
  sample_t res_sample;

  assign stat.scan_last = (idx_r == idx_t'(TABLE_DEPTH - 1));
  assign stat.out_free  = !out_valid_r || out_tready;

  assign ev    = rd_pend_r && rd_valid_r;
  assign ev_eq = (rd_tick_r == req_tick_r);
  assign ev_lt = (rd_tick_r < req_tick_r);

  assign ins_sample = (match_r && (match_sample_r > req_sample_r)) ? match_sample_r
                                                                  : req_sample_r;
  assign ins_idx    = match_r ? match_idx_r : free_idx_r;
  assign ins_wr     = cmd.finish && (req_op_r == OP_INSERT) && (match_r || free_r);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_tick_r   <= mem_tick[idx_r];
      rd_sample_r <= mem_sample[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_wr) begin
      mem_tick[ins_idx]   <= req_tick_r;
      mem_sample[ins_idx] <= ins_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      max_dist_r <= '1;
      rd_pend_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_dist_r <= cfg_wr_data;
      end
      rd_pend_r <= cmd.read;
      if (cmd.start) begin
        idx_r <= '0;
      end else if (cmd.read && !stat.scan_last) begin
        idx_r <= idx_r + idx_t'(1);
      end
      if (ev && (req_op_r == OP_PRUNE) && ev_lt) begin
        valid_r[rd_idx_r] <= 1'b0;
      end
      if (ins_wr) begin
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_idx_r   <= idx_r;
      rd_valid_r <= valid_r[idx_r];
    end
    if (cmd.start) begin
      req_op_r     <= in_op;
      req_tick_r   <= in_tick;
      req_sample_r <= in_sample;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
      exact_r      <= 1'b0;
      lo_r         <= 1'b0;
      hi_r         <= 1'b0;
    end else if (rd_pend_r) begin
      if (!rd_valid_r && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (ev) begin
        if (ev_eq) begin
          match_r        <= 1'b1;
          match_idx_r    <= rd_idx_r;
          match_sample_r <= rd_sample_r;
          exact_r        <= 1'b1;
          exact_sample_r <= rd_sample_r;
        end
        if (req_op_r == OP_NEWEST) begin
          if (!lo_r || (rd_tick_r > lo_tick_r)) begin
            lo_r        <= 1'b1;
            lo_tick_r   <= rd_tick_r;
            lo_sample_r <= rd_sample_r;
          end
        end else if (ev_lt) begin
          if (!lo_r || (rd_tick_r > lo_tick_r)) begin
            lo_r        <= 1'b1;
            lo_tick_r   <= rd_tick_r;
            lo_sample_r <= rd_sample_r;
          end
        end else if (!ev_eq) begin
          if (!hi_r || (rd_tick_r < hi_tick_r)) begin
            hi_r        <= 1'b1;
            hi_tick_r   <= rd_tick_r;
            hi_sample_r <= rd_sample_r;
          end
        end
      end
    end
    if (cmd.calc) begin
      d_lo_r <= req_tick_r - lo_tick_r;
      d_hi_r <= hi_tick_r - req_tick_r;
    end
  end

  assign lo_wins = (d_lo_r <= d_hi_r);
  assign lo_far  = (d_lo_r > max_dist_r);
  assign hi_far  = (d_hi_r > max_dist_r);

  always_comb begin
    res_status = ST_OK;
    res_tick   = '0;
    res_sample = '0;
    unique case (req_op_r)
      OP_INSERT: begin
        res_tick = req_tick_r;
        if (match_r || free_r) begin
          res_sample = ins_sample;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_NEAREST: begin
        priority if (exact_r) begin
          res_tick   = req_tick_r;
          res_sample = exact_sample_r;
        end else if (!lo_r && !hi_r) begin
          res_status = ST_EMPTY;
        end else if (lo_r && (!hi_r || lo_wins)) begin
          res_tick   = lo_tick_r;
          res_sample = lo_sample_r;
          res_status = lo_far ? ST_FAR : ST_OK;
        end else begin
          res_tick   = hi_tick_r;
          res_sample = hi_sample_r;
          res_status = hi_far ? ST_FAR : ST_OK;
        end
      end
      OP_PRUNE: begin
        res_status = ST_OK;
      end
      OP_NEWEST: begin
        if (lo_r) begin
          res_tick   = lo_tick_r;
          res_sample = lo_sample_r;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_tick_r   <= res_tick;
      out_sample_r <= res_sample;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sample_r, out_tick_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

// ===== src/timestamped_sample_store_nearest_top.sv =====
// Top level of the timestamped sample store with nearest lookup.
//
//   Channel   Direction  Payload
//   in_       slave      tuser: operation; tdata: tick, sample
//   out_      master     tuser: status; tdata: found_tick, found_sample
//   cfg_      write      max_distance
//
// Every request passes, from its acceptance to the next acceptance, through
// the idle state that accepts it, the scan that reads one table entry per
// cycle from the single-port entry memory, a drain state for the read
// latency and the states for the neighbor choice and the result load. Reset is
// synchronous and active low; it empties the table and sets max_distance to
// all ones. A result that waits on out_tready holds the block before its next
// result load.
`default_nettype none
module timestamped_sample_store_nearest_top
  import tsn_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [DATA_W-1:0]  in_tdata,   // tick [31:0], sample [39:32]
  input  wire  [OP_W-1:0]    in_tuser,   // operation [1:0]
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [DATA_W-1:0]  out_tdata,  // found_tick [31:0], found_sample [39:32]
  output logic [ST_W-1:0]    out_tuser,  // status [1:0]
  input  wire                cfg_wr_en,
  input  wire  [TICK_W-1:0]  cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  tsn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsn_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_tick     (in_tdata[TICK_W-1:0]),
    .in_sample   (in_tdata[DATA_W-1:TICK_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire
